/* src/abde_pkg.sv */
// Shared types and constants for the ARGB8888 draw engine.
// No dependencies; imported by every module of the block.
package abde_pkg;

  localparam int CW     = 14;  // internal signed coordinate width
  localparam int QDEPTH = 2;   // job queue depth

  // opcodes of the command channel
  localparam logic [2:0] OPC_CLEAR = 3'd0;
  localparam logic [2:0] OPC_PIXEL = 3'd1;
  localparam logic [2:0] OPC_FILL  = 3'd2;
  localparam logic [2:0] OPC_FRAME = 3'd3;
  localparam logic [2:0] OPC_GLYPH = 3'd4;
  localparam logic [2:0] OPC_READ  = 3'd5;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [10:0]        rect_w;
    logic [10:0]        rect_h;
    logic [31:0]        colour;
    logic [63:0]        glyph_rows;
    logic               glyph_found;
    logic [3:0]         scale;
  } cmd_t;

  typedef struct packed {
    logic signed [12:0] next_x;
    logic [31:0]        pixel_value;
    logic               dirty;
  } res_t;

  typedef enum logic [2:0] {
    K_NOP, K_CLEAR, K_PIXEL, K_FILL, K_FRAME, K_GLYPH, K_READ
  } kind_t;

  // classified job handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [10:0]        w;
    logic [10:0]        h;
    logic [31:0]        colour;
    logic [63:0]        rows;
    logic [3:0]         scale;   // already clamped
    logic signed [12:0] next_x;
  } job_t;

  typedef enum logic [3:0] {
    B_CLR, B_IDLE, B_SETUP, B_GEN, B_ADDR, B_RD, B_MUL, B_WR, B_DONE
  } bstate_t;

  // exact v/255 for v < 65281
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
    return t[15:8];
  endfunction

endpackage

/* src/abde_fifo.sv */
// Short job queue between the command front and the pixel back end.
// Depends on abde_pkg (job_t, QDEPTH).
module abde_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  abde_pkg::job_t din,
  input  logic           pop,
  output abde_pkg::job_t dout,
  output logic           full,
  output logic           empty
);
  import abde_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  job_t          slots [QDEPTH];
  logic [PW-1:0] wp, rp;
  logic [NW-1:0] cnt;

  assign full  = (cnt == NW'(QDEPTH));
  assign empty = (cnt == '0);
  assign dout  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(QDEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (pop) begin
        rp <= (rp == PW'(QDEPTH - 1)) ? '0 : rp + PW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + NW'(1);
      end else if (pop && !push) begin
        cnt <= cnt - NW'(1);
      end
    end
  end

endmodule

/* src/abde_front.sv */
// Command front: takes command transfers, classifies them into jobs.
// Depends on abde_pkg (cmd_t, job_t, opcodes).
module abde_front #(
  parameter int MAX_SCALE = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  abde_pkg::cmd_t cmd,
  input  logic           stall,
  input  logic           q_full,
  output logic           q_push,
  output abde_pkg::job_t q_data
);
  import abde_pkg::*;

  logic               fv;
  job_t               job, job_next;
  logic [3:0]         s_cl;
  logic signed [CW-1:0] x14, nx14;

  always_comb begin
    s_cl = (cmd.scale > MAX_SCALE) ? 4'(MAX_SCALE) : cmd.scale;
    x14  = {{(CW-12){cmd.pos_x[11]}}, cmd.pos_x};
    nx14 = x14 + $signed({{(CW-7){1'b0}}, s_cl, 3'b000});
    job_next.x      = x14;
    job_next.y      = {{(CW-12){cmd.pos_y[11]}}, cmd.pos_y};
    job_next.w      = cmd.rect_w;
    job_next.h      = cmd.rect_h;
    job_next.colour = cmd.colour;
    job_next.rows   = cmd.glyph_rows;
    job_next.scale  = s_cl;
    job_next.next_x = {cmd.pos_x[11], cmd.pos_x};
    case (cmd.opcode)
      OPC_CLEAR: job_next.kind = K_CLEAR;
      OPC_PIXEL: job_next.kind = K_PIXEL;
      OPC_FILL:  job_next.kind = K_FILL;
      OPC_FRAME: job_next.kind = (cmd.rect_w != '0 && cmd.rect_h != '0) ? K_FRAME : K_NOP;
      OPC_GLYPH: begin
        // no scale: nothing drawn, no advance; no glyph: advance only
        job_next.kind = (s_cl != '0 && cmd.glyph_found) ? K_GLYPH : K_NOP;
        if (s_cl != '0) begin
          job_next.next_x = nx14[12:0];
        end
      end
      OPC_READ:  job_next.kind = K_READ;
      default:   job_next.kind = K_NOP;
    endcase
  end

  assign q_push    = fv && !q_full;
  assign q_data    = job;
  assign cmd_ready = !stall && (!fv || !q_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (cmd_valid && cmd_ready) begin
      fv <= 1'b1;
    end else if (q_push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      job <= job_next;
    end
  end

endmodule

/* src/abde_back.sv */
// Pixel back end: walks the pixels of each job, blends into the frame
// store, runs clearing sweeps and holds the result register. Uses abde_pkg.
module abde_back #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    act_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   act_h,
  input  logic                              clr_req,
  input  logic                              q_empty,
  output logic                              q_pop,
  input  abde_pkg::job_t                    q_data,
  output logic                              clearing,
  output logic                              res_valid,
  input  logic                              res_ready,
  output abde_pkg::res_t                    res
);
  import abde_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int MW    = $clog2(DEPTH);
  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int HB    = $clog2(MAX_HEIGHT + 1);
  localparam int XB    = $clog2(MAX_WIDTH);
  localparam int YB    = $clog2(MAX_HEIGHT);
  localparam logic signed [CW-1:0] C_ONE  = 1;
  localparam logic signed [CW-1:0] C_ZERO = 0;

  logic [31:0] mem [DEPTH];

  bstate_t state, state_next;
  job_t    job;
  logic    clr_cmd, dirty, last_q, sub, phase;
  logic [MW-1:0] clr_cnt, addr, waddr;
  logic signed [CW-1:0] px, py, cx, cy, xs, xe, ye, bx, by;
  logic [10:0] k;
  logic [2:0]  gx, gy;
  logic [3:0]  sx, sy;
  logic [31:0] rdata, pix_res, wdata, blend;
  logic [15:0] prs_r, prs_g, prs_b, prd_r, prd_g, prd_b, pa;
  logic        we;

  logic signed [CW-1:0] aw_s, ah_s, w_s, h_s, s_s, k_s;
  logic signed [CW-1:0] gen_px, gen_py, x0, x1, y0, y1;
  logic gen_has, gen_last, gen_clip, draw_ok, cell_end, fill_empty;
  logic [7:0] alpha, alpha_inv;
  logic [3:0] s_m1;
  logic [YB+WB-1:0] row_base;

  assign alpha     = job.colour[31:24];
  assign alpha_inv = ~alpha;  // 255 - alpha, kept 8 bits wide for the products
  assign s_m1     = job.scale - 4'd1;
  assign aw_s     = $signed({{(CW-WB){1'b0}}, act_w});
  assign ah_s     = $signed({{(CW-HB){1'b0}}, act_h});
  assign w_s      = $signed({{(CW-11){1'b0}}, job.w});
  assign h_s      = $signed({{(CW-11){1'b0}}, job.h});
  assign s_s      = $signed({{(CW-4){1'b0}}, job.scale});
  assign k_s      = $signed({{(CW-11){1'b0}}, k});
  assign clearing = (state == B_CLR);

  // clipped fill bounds
  always_comb begin
    x0 = (job.x < C_ZERO) ? C_ZERO : job.x;
    y0 = (job.y < C_ZERO) ? C_ZERO : job.y;
    x1 = job.x + w_s;
    y1 = job.y + h_s;
    if (x1 > aw_s) begin
      x1 = aw_s;
    end
    if (y1 > ah_s) begin
      y1 = ah_s;
    end
    fill_empty = (x0 >= x1) || (y0 >= y1);
  end

  // pixel generator: coordinate of the current step and whether it ends the job
  always_comb begin
    gen_px   = job.x;
    gen_py   = job.y;
    gen_has  = 1'b1;
    gen_last = 1'b1;
    cell_end = 1'b1;
    case (job.kind)
      K_FILL: begin
        gen_px   = cx;
        gen_py   = cy;
        gen_last = (cx + C_ONE >= xe) && (cy + C_ONE >= ye);
      end
      K_FRAME: begin
        if (!phase) begin
          gen_px   = job.x + k_s;
          gen_py   = sub ? (job.y + h_s - C_ONE) : job.y;
          gen_last = sub && (k == job.w - 11'd1) && (job.h <= 11'd2);
        end else begin
          gen_px   = sub ? (job.x + w_s - C_ONE) : job.x;
          gen_py   = job.y + k_s;
          gen_last = sub && (k == job.h - 11'd2);
        end
      end
      K_GLYPH: begin
        gen_px   = bx + $signed({{(CW-4){1'b0}}, sx});
        gen_py   = by + $signed({{(CW-4){1'b0}}, sy});
        gen_has  = job.rows[{~gy, ~gx}];
        cell_end = !gen_has || (sx == s_m1 && sy == s_m1);
        gen_last = cell_end && (gx == 3'd7) && (gy == 3'd7);
      end
      default: begin
      end
    endcase
    gen_clip = (gen_px >= C_ZERO) && (gen_py >= C_ZERO) &&
               (gen_px < aw_s) && (gen_py < ah_s);
    draw_ok  = gen_has && gen_clip && (alpha != 8'd0);
  end

  // blend from registered products
  always_comb begin
    blend = {alpha + div255(pa), div255(prs_r + prd_r),
             div255(prs_g + prd_g), div255(prs_b + prd_b)};
    we    = (state == B_CLR) || (state == B_WR);
    waddr = (state == B_CLR) ? clr_cnt : addr;
    if (state == B_CLR) begin
      wdata = '0;
    end else if (alpha == 8'hff) begin
      wdata = job.colour;
    end else begin
      wdata = blend;
    end
    row_base = py[YB-1:0] * act_w;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[addr];
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      B_CLR: begin
        if (clr_cnt == MW'(DEPTH - 1)) begin
          state_next = clr_cmd ? B_DONE : B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = B_SETUP;
        end
      end
      B_SETUP: begin
        case (job.kind)
          K_CLEAR: state_next = B_CLR;
          K_READ:  state_next = gen_clip ? B_ADDR : B_DONE;
          K_PIXEL: state_next = B_GEN;
          K_FILL:  state_next = fill_empty ? B_DONE : B_GEN;
          K_FRAME: state_next = B_GEN;
          K_GLYPH: state_next = B_GEN;
          default: state_next = B_DONE;
        endcase
      end
      B_GEN: begin
        if (draw_ok) begin
          state_next = B_ADDR;
        end else if (gen_last) begin
          state_next = B_DONE;
        end
      end
      B_ADDR:  state_next = (job.kind == K_READ || alpha != 8'hff) ? B_RD : B_WR;
      B_RD:    state_next = B_MUL;
      B_MUL:   state_next = (job.kind == K_READ) ? B_DONE : B_WR;
      B_WR:    state_next = last_q ? B_DONE : B_GEN;
      B_DONE: begin
        if (!res_valid || res_ready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
    if (clr_req) begin
      state_next = B_CLR;
      q_pop      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLR;
      clr_cnt   <= '0;
      clr_cmd   <= 1'b0;
      dirty     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (state == B_CLR) begin
        clr_cnt <= clr_cnt + MW'(1);
      end
      if (state == B_SETUP && job.kind == K_CLEAR) begin
        clr_cnt <= '0;
        clr_cmd <= 1'b1;
        dirty   <= 1'b0;
      end
      if (state == B_WR) begin
        dirty <= 1'b1;
      end
      if (state == B_DONE && state_next == B_IDLE) begin
        res_valid <= 1'b1;
        clr_cmd   <= 1'b0;
      end
      if (clr_req) begin
        clr_cnt <= '0;
        clr_cmd <= 1'b0;
        dirty   <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        job <= q_data;
      end
      B_SETUP: begin
        px      <= job.x;
        py      <= job.y;
        cx      <= x0;
        cy      <= y0;
        xs      <= x0;
        xe      <= x1;
        ye      <= y1;
        k       <= '0;
        sub     <= 1'b0;
        phase   <= 1'b0;
        gx      <= '0;
        gy      <= '0;
        sx      <= '0;
        sy      <= '0;
        bx      <= job.x;
        by      <= job.y;
        pix_res <= '0;
      end
      B_GEN: begin
        px     <= gen_px;
        py     <= gen_py;
        last_q <= gen_last;
        case (job.kind)
          K_FILL: begin
            if (cx + C_ONE < xe) begin
              cx <= cx + C_ONE;
            end else begin
              cx <= xs;
              cy <= cy + C_ONE;
            end
          end
          K_FRAME: begin
            if (!sub) begin
              sub <= 1'b1;
            end else begin
              sub <= 1'b0;
              if (!phase && k == job.w - 11'd1) begin
                phase <= 1'b1;
                k     <= 11'd1;
              end else begin
                k <= k + 11'd1;
              end
            end
          end
          K_GLYPH: begin
            if (cell_end) begin
              sx <= '0;
              sy <= '0;
              if (gx == 3'd7) begin
                gx <= '0;
                bx <= job.x;
                gy <= gy + 3'd1;
                by <= by + s_s;
              end else begin
                gx <= gx + 3'd1;
                bx <= bx + s_s;
              end
            end else if (sx == s_m1) begin
              sx <= '0;
              sy <= sy + 4'd1;
            end else begin
              sx <= sx + 4'd1;
            end
          end
          default: begin
          end
        endcase
      end
      B_ADDR: begin
        addr <= MW'(row_base) + MW'(px[XB-1:0]);
      end
      B_MUL: begin
        pix_res <= rdata;
        prs_r   <= job.colour[23:16] * alpha;
        prs_g   <= job.colour[15:8] * alpha;
        prs_b   <= job.colour[7:0] * alpha;
        prd_r   <= rdata[23:16] * alpha_inv;
        prd_g   <= rdata[15:8] * alpha_inv;
        prd_b   <= rdata[7:0] * alpha_inv;
        pa      <= rdata[31:24] * alpha_inv;
      end
      B_DONE: begin
        if (state_next == B_IDLE) begin
          res.next_x      <= job.next_x;
          res.pixel_value <= (job.kind == K_READ) ? pix_res : 32'd0;
          res.dirty       <= dirty;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_wr_sets_dirty: assert property (@(posedge clk) disable iff (rst)
    (state == B_WR && !clr_req) |=> dirty)
    else $error("pixel write did not mark the store dirty");
  a_addr_clipped: assert property (@(posedge clk) disable iff (rst)
    (state == B_ADDR) |-> (px >= C_ZERO && py >= C_ZERO && px < aw_s && py < ah_s))
    else $error("address formed for a clipped pixel");
  a_mul_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == B_MUL) |-> ($past(state) == B_RD))
    else $error("blend stage entered without a store read");
`endif

endmodule

/* src/alpha_blend_draw_engine.sv */
// ARGB8888 draw engine: clear, blend pixel, fill rect, outline rect, scaled
// 8x8 glyph and pixel read on an internal frame store of MAX_WIDTH*MAX_HEIGHT
// words, clipped to the fb_width/fb_height registers. Each command transfer
// gives one result transfer (next_x, pixel_value, dirty), unless a register
// write aborts its job. The back end handles a command in steps: queue pop,
// setup, then for each generated pixel a generate step, which is all that a
// pixel that is clipped, not set in the glyph, or drawn with alpha 0 gets;
// a blended pixel then takes address, store read, multiply and write steps,
// an opaque one address and write; last comes the result. A read takes the
// address, store read and multiply steps. Pixels go through the frame store
// one at a time. Clear, reset, and any register write sweep the whole store
// at one word a cycle, and no command is taken during that sweep. A
// two-entry queue lets new commands be classified while the back end is
// still drawing, and a result register lets the back end go on while a
// result waits. Depends on abde_pkg, abde_front, abde_fifo, abde_back.
module alpha_blend_draw_engine #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_SCALE  = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  abde_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output abde_pkg::res_t res,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import abde_pkg::*;

  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = $clog2(MAX_HEIGHT + 1);

  logic [9:0]    fb_width;
  logic [8:0]    fb_height;
  logic [WB-1:0] act_w;
  logic [HB-1:0] act_h;
  logic          cfg_wr, clearing, q_push, q_pop, q_full, q_empty;
  job_t          q_in, q_out;

  // APB: pready is tied high; register index is paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = {22'd0, fb_width};
      REG_HEIGHT: prdata = {23'd0, fb_height};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width  <= '0;
      fb_height <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_WIDTH:  fb_width  <= pwdata[9:0];
        REG_HEIGHT: fb_height <= pwdata[8:0];
        default: begin
        end
      endcase
    end
  end

  // oversize registers act as the store limits
  assign act_w = (fb_width > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(fb_width);
  assign act_h = (fb_height > MAX_HEIGHT) ? HB'(MAX_HEIGHT) : HB'(fb_height);

  abde_front #(
    .MAX_SCALE(MAX_SCALE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .stall    (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  abde_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_in),
    .pop  (q_pop),
    .dout (q_out),
    .full (q_full),
    .empty(q_empty)
  );

  // any register write resizes and therefore blanks the store
  abde_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .act_w    (act_w),
    .act_h    (act_h),
    .clr_req  (cfg_wr),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_data   (q_out),
    .clearing (clearing),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

endmodule
